// ----- hdl/vlc_pkg.sv -----
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and constants for the velocity level curve pipeline.
// ----------------------------------------------------------------------------
package vlc_pkg;

	localparam int BYTE_W   = 8;
	localparam int BP_W     = 24;
	localparam int LVL_W    = 24;
	localparam int RATE_W   = 32;
	localparam int CFG_DW   = 32;
	localparam int CFG_AW   = 2;
	localparam int PROD_W   = 16;

	typedef enum logic [CFG_AW-1:0] {
		REG_BREAK_POINTS   = 2'd0,
		REG_SEGMENT_LEVELS = 2'd1,
		REG_SEGMENT_RATES  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_KEEP       = 3'd0,
		MODE_ADD_BENT   = 3'd1,
		MODE_ADD_MARGIN = 3'd2,
		MODE_ADD_SHR    = 3'd3,
		MODE_KEEP_ALT   = 3'd4,
		MODE_SUB_SHR    = 3'd5,
		MODE_SUB_MARGIN = 3'd6,
		MODE_SUB_BENT   = 3'd7
	} mode_t;

	localparam logic [3:0] BOOST_MUL = 4'd12;
	localparam logic [6:0] LEVEL_MAX = 7'h7F;
	localparam logic [7:0] AMP_MAX   = 8'hFF;

	typedef struct packed {
		logic [7:0]        margin;
		logic [7:0]        base;
		logic [3:0]        shift;
		logic              boost;
		mode_t             mode;
		logic [7:0]        total_level;
		logic signed [7:0] vol_bias;
	} seg_t;

	typedef struct packed {
		logic [6:0]        level;
		logic [7:0]        total_level;
		logic signed [7:0] vol_bias;
	} lvl_t;

endpackage

// ----- hdl/vlc_segment.sv -----
// ----------------------------------------------------------------------------
// vlc_segment
// Stage 1: picks the curve segment from the break points and forms the margin.
// ----------------------------------------------------------------------------
module vlc_segment (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  logic [7:0]                  velocity,
	input  logic [7:0]                  total_level,
	input  logic signed [7:0]           vol_bias,
	input  logic [vlc_pkg::BP_W-1:0]    break_points,
	input  logic [vlc_pkg::LVL_W-1:0]   segment_levels,
	input  logic [vlc_pkg::RATE_W-1:0]  segment_rates,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output vlc_pkg::seg_t               seg
);
	import vlc_pkg::*;

	logic       gt0, gt1, gt2;
	logic [7:0] point, base, rate;
	logic       valid_s1;
	seg_t       seg_s1;
	seg_t       seg_d;

	assign gt0 = velocity > break_points[7:0];
	assign gt1 = gt0 && (velocity > break_points[15:8]);
	assign gt2 = gt1 && (velocity > break_points[23:16]);

	always_comb begin
		point = 8'd0;
		base  = 8'd0;
		rate  = segment_rates[7:0];
		if (gt2) begin
			point = break_points[23:16];
			base  = segment_levels[23:16];
			rate  = segment_rates[31:24];
		end else if (gt1) begin
			point = break_points[15:8];
			base  = segment_levels[15:8];
			rate  = segment_rates[23:16];
		end else if (gt0) begin
			point = break_points[7:0];
			base  = segment_levels[7:0];
			rate  = segment_rates[15:8];
		end
		seg_d.margin      = velocity - point;
		seg_d.base        = base;
		seg_d.shift       = rate[7:4];
		seg_d.boost       = rate[3];
		seg_d.mode        = mode_t'(rate[2:0]);
		seg_d.total_level = total_level;
		seg_d.vol_bias    = vol_bias;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			seg_s1 <= seg_d;
		end
	end

	assign dn_valid = valid_s1;
	assign seg      = seg_s1;

endmodule

// ----- hdl/vlc_level.sv -----
// ----------------------------------------------------------------------------
// vlc_level
// Stage 2: bends the margin by the rate byte, wraps and clamps the level.
// ----------------------------------------------------------------------------
module vlc_level (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  vlc_pkg::seg_t seg,
	output logic          dn_valid,
	input  logic          dn_ready,
	output vlc_pkg::lvl_t lvl
);
	import vlc_pkg::*;

	logic [10:0] boost_prod;
	logic [25:0] boost_wide;
	logic [7:0]  bent, shr, sum;
	logic        valid_s2;
	lvl_t        lvl_s2;
	lvl_t        lvl_d;

	assign boost_prod = 11'(seg.margin[6:0]) * 11'(BOOST_MUL);
	assign boost_wide = 26'(boost_prod) << seg.shift;
	assign bent       = seg.boost ? boost_wide[10:3] : 8'(seg.margin << seg.shift);
	assign shr        = seg.margin >> seg.shift;

	always_comb begin
		case (seg.mode)
			MODE_ADD_BENT:   sum = seg.base + bent;
			MODE_ADD_MARGIN: sum = seg.base + seg.margin;
			MODE_ADD_SHR:    sum = seg.base + shr;
			MODE_SUB_SHR:    sum = seg.base - shr;
			MODE_SUB_MARGIN: sum = seg.base - seg.margin;
			MODE_SUB_BENT:   sum = seg.base - bent;
			default:         sum = seg.base;
		endcase
		// anything at or above 128, wrapped negatives included, pins to max
		lvl_d.level       = sum[7] ? LEVEL_MAX : sum[6:0];
		lvl_d.total_level = seg.total_level;
		lvl_d.vol_bias    = seg.vol_bias;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lvl_s2 <= lvl_d;
		end
	end

	assign dn_valid = valid_s2;
	assign lvl      = lvl_s2;

endmodule

// ----- hdl/vlc_scale.sv -----
// ----------------------------------------------------------------------------
// vlc_scale
// Stages 3 and 4: scales the level by total level, adds the bias, inverts.
// ----------------------------------------------------------------------------
module vlc_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  vlc_pkg::lvl_t lvl,
	output logic          dn_valid,
	input  logic          dn_ready,
	output logic [7:0]    attenuation
);
	import vlc_pkg::*;

	logic [7:0]        lev_p1;
	logic [8:0]        scl;
	logic [16:0]       prod_full;
	logic [PROD_W-1:0] prod_s3, prod_m1;
	logic signed [7:0] bias_s3;
	logic              valid_s3, en_s3;
	logic [7:0]        amp, clamped;
	logic [9:0]        sum;
	logic              valid_s4, en_s4;
	logic [7:0]        attenuation_s4;

	assign lev_p1    = {1'b0, lvl.level} + 8'd1;
	assign scl       = 9'h100 - {1'b0, lvl.total_level};
	assign prod_full = 17'(lev_p1) * 17'(scl);

	assign en_s4    = !valid_s4 || dn_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign up_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= up_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			prod_s3 <= prod_full[PROD_W-1:0];
			bias_s3 <= lvl.vol_bias;
		end
	end

	// (p * 512 - 1) >> 16 equals (p - 1) >> 7 since p is never zero
	assign prod_m1 = prod_s3 - 16'd1;
	assign amp     = prod_m1[14:7];
	assign sum     = {2'b00, amp} + {{2{bias_s3[7]}}, bias_s3};

	always_comb begin
		if (sum[9]) begin
			clamped = 8'd0;
		end else if (sum[8]) begin
			clamped = AMP_MAX;
		end else begin
			clamped = sum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			attenuation_s4 <= ~clamped;
		end
	end

	assign dn_valid    = valid_s4;
	assign attenuation = attenuation_s4;

	a_prod_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> prod_s3 != 16'd0)
		else $error("scale product is zero");

	a_prod_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> prod_s3 <= 16'd32768)
		else $error("scale product out of range");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_s4) |=> (valid_s3 && $stable(prod_s3) && $stable(bias_s3)))
		else $error("stage 3 lost its beat during a stall");

endmodule

// ----- hdl/velocity_level_curve.sv -----
// ----------------------------------------------------------------------------
// velocity_level_curve
// Maps a note velocity through a four-segment level curve to a TL byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per note: velocity,
//   total_level and the signed vol_bias. Output channel (out_valid/out_ready)
//   returns one attenuation beat per input beat, in order.
//   The curve registers are written through cfg_we/cfg_index/cfg_wdata while
//   no beat is in flight; index 0 break points, 1 segment levels, 2 rates.
//   Writes to other indexes are ignored.
// Stages: segment select, level bend, multiply, bias and clamp, in that order
//   from input beat to output beat, one register stage each.
// Throughput: one beat per cycle, sustained while out_ready is high.
// Reset: arst_n clears the curve registers and empties the pipeline.
// Stall: when out_ready is low the stages fill up behind the output register;
//   in_ready drops only once every stage holds a beat. Nothing is dropped.
// ----------------------------------------------------------------------------
module velocity_level_curve (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vlc_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [vlc_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   velocity,
	input  logic [7:0]                   total_level,
	input  logic signed [7:0]            vol_bias,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   attenuation
);
	import vlc_pkg::*;

	logic [BP_W-1:0]   break_points_q;
	logic [LVL_W-1:0]  segment_levels_q;
	logic [RATE_W-1:0] segment_rates_q;

	logic seg_valid, seg_ready;
	logic lvl_valid, lvl_ready;
	seg_t seg;
	lvl_t lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_points_q   <= '0;
			segment_levels_q <= '0;
			segment_rates_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BREAK_POINTS:   break_points_q   <= cfg_wdata[BP_W-1:0];
				REG_SEGMENT_LEVELS: segment_levels_q <= cfg_wdata[LVL_W-1:0];
				REG_SEGMENT_RATES:  segment_rates_q  <= cfg_wdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	vlc_segment u_segment (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (in_valid),
		.up_ready       (in_ready),
		.velocity       (velocity),
		.total_level    (total_level),
		.vol_bias       (vol_bias),
		.break_points   (break_points_q),
		.segment_levels (segment_levels_q),
		.segment_rates  (segment_rates_q),
		.dn_valid       (seg_valid),
		.dn_ready       (seg_ready),
		.seg            (seg)
	);

	vlc_level u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (seg_valid),
		.up_ready (seg_ready),
		.seg      (seg),
		.dn_valid (lvl_valid),
		.dn_ready (lvl_ready),
		.lvl      (lvl)
	);

	vlc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (lvl_valid),
		.up_ready    (lvl_ready),
		.lvl         (lvl),
		.dn_valid    (out_valid),
		.dn_ready    (out_ready),
		.attenuation (attenuation)
	);

endmodule

// ----- bench/vlc_curve_checker.sv -----
// ----------------------------------------------------------------------------
// vlc_curve_checker
// Watches the note and attenuation channels of velocity_level_curve. It keeps
// its own copy of the curve registers, works out the attenuation byte of every
// accepted note beat and compares each accepted output beat, in order, with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vlc_curve_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vlc_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [vlc_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [7:0]                   velocity,
	input  logic [7:0]                   total_level,
	input  logic signed [7:0]            vol_bias,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [7:0]                   attenuation,
	output int                           mismatches,
	output int                           outstanding
);
	import vlc_pkg::*;

	localparam int PRED_DEPTH = 16;

	logic [BP_W-1:0]   points_q;
	logic [LVL_W-1:0]  levels_q;
	logic [RATE_W-1:0] rates_q;
	logic [7:0]        pred_mem [PRED_DEPTH];
	logic [3:0]        wr_q;
	logic [3:0]        rd_q;

	function automatic logic [7:0] curve_attenuation(
		input logic [7:0]        vel,
		input logic [7:0]        tl,
		input logic signed [7:0] bias
	);
		logic [7:0]  point;
		logic [7:0]  base;
		logic [7:0]  rate;
		logic [7:0]  margin;
		logic [7:0]  lev;
		logic [7:0]  amp;
		logic [3:0]  shift;
		logic        boost;
		mode_t       mode;
		logic [31:0] bent;
		logic [31:0] scale;
		int          sum;
		point = 8'd0;
		base  = 8'd0;
		rate  = rates_q[7:0];
		for (int k = 0; k < 3; k++) begin
			if (vel > points_q[k*8 +: 8]) begin
				point = points_q[k*8 +: 8];
				base  = levels_q[k*8 +: 8];
				rate  = rates_q[(k+1)*8 +: 8];
			end else begin
				break;
			end
		end
		shift  = rate[7:4];
		boost  = rate[3];
		mode   = mode_t'(rate[2:0]);
		margin = vel - point;
		if (boost)
			bent = ((32'(margin[6:0]) * 32'(BOOST_MUL)) << shift) >> 3;
		else
			bent = 32'(margin) << shift;
		case (mode)
			MODE_ADD_BENT:   lev = base + bent[7:0];
			MODE_ADD_MARGIN: lev = base + margin;
			MODE_ADD_SHR:    lev = base + (margin >> shift);
			MODE_SUB_SHR:    lev = base - (margin >> shift);
			MODE_SUB_MARGIN: lev = base - margin;
			MODE_SUB_BENT:   lev = base - bent[7:0];
			default:         lev = base;
		endcase
		if (lev > {1'b0, LEVEL_MAX})
			lev = {1'b0, LEVEL_MAX};
		scale = (32'(lev) + 32'd1) * (32'd256 - 32'(tl));
		amp   = 8'((scale * 32'd512 - 32'd1) >> 16);
		sum   = int'(amp) + int'(bias);
		if (sum < 0)
			sum = 0;
		if (sum > int'(AMP_MAX))
			sum = int'(AMP_MAX);
		return ~8'(sum);
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		logic [7:0] want;
		int         fill;
		if (!arst_n) begin
			points_q    <= '0;
			levels_q    <= '0;
			rates_q     <= '0;
			mismatches  <= 0;
			outstanding <= 0;
			wr_q        <= '0;
			rd_q        <= '0;
		end else begin
			fill = outstanding;
			if (cfg_we) begin
				case (cfg_index)
					REG_BREAK_POINTS:   points_q <= cfg_wdata[BP_W-1:0];
					REG_SEGMENT_LEVELS: levels_q <= cfg_wdata[LVL_W-1:0];
					REG_SEGMENT_RATES:  rates_q  <= cfg_wdata[RATE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pred_mem[wr_q] <= curve_attenuation(velocity, total_level, vol_bias);
				wr_q           <= wr_q + 4'd1;
				fill           = fill + 1;
			end
			if (out_valid && out_ready) begin
				if (outstanding == 0) begin
					$display("%0t: unexpected attenuation beat, expected none, got %0d",
						$time, attenuation);
					mismatches <= mismatches + 1;
				end else begin
					want = pred_mem[rd_q];
					rd_q <= rd_q + 4'd1;
					fill = fill - 1;
					if (attenuation !== want) begin
						$display("%0t: attenuation wrong, expected %0d, got %0d",
							$time, want, attenuation);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= fill;
		end
	end

endmodule

// ----- bench/tb_velocity_level_curve.sv -----
// ----------------------------------------------------------------------------
// tb_velocity_level_curve
// Drives velocity_level_curve with directed notes for every bend mode and
// segment, then with random notes over a series of curve tables (all zero,
// all ones, ordered and unordered break points). Note beats come in random
// bursts, the output side stalls on its own pattern, and the checker beside
// the block predicts and compares every attenuation beat.
// ----------------------------------------------------------------------------
module tb_velocity_level_curve;
	import vlc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PIPE_LATENCY  = 4;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_NOTES   = 150;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          velocity;
	logic [7:0]          total_level;
	logic signed [7:0]   vol_bias;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          attenuation;

	int                  mismatches;
	int                  outstanding;
	int                  cycle_count;
	int                  burst_left;
	int                  stall_left;
	int                  stall_mode;
	logic [BP_W-1:0]     cur_points;

	velocity_level_curve uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.velocity    (velocity),
		.total_level (total_level),
		.vol_bias    (vol_bias),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.attenuation (attenuation)
	);

	vlc_curve_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.velocity    (velocity),
		.total_level (total_level),
		.vol_bias    (vol_bias),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.attenuation (attenuation),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("velocity_level_curve: mismatch");
		$finish;
	end

	// output stall pattern: always ready, coin flip, mostly stalled, alternating blocks
	initial stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 256);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((stall_left / 8) % 2) == 0;
		endcase
	end

	task automatic send_note(input logic [7:0] v, input logic [7:0] t, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		velocity    <= v;
		total_level <= t;
		vol_bias    <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_curve(input logic [31:0] points, input logic [31:0] levels,
		input logic [31:0] rates);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BREAK_POINTS;
		cfg_wdata <= points;
		@(posedge clk);
		cfg_index <= REG_SEGMENT_LEVELS;
		cfg_wdata <= levels;
		@(posedge clk);
		cfg_index <= REG_SEGMENT_RATES;
		cfg_wdata <= rates;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_points = points[BP_W-1:0];
	endtask

	task automatic random_note();
		logic [7:0] v;
		logic [7:0] t;
		logic [7:0] b;
		int         pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			v = $urandom_range(0, 255);
		else if (pick < 8)
			v = cur_points[$urandom_range(0, 2)*8 +: 8] + 8'($urandom_range(0, 4) - 2);
		else
			v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		t = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 255))
			: ($urandom_range(0, 1) ? 8'hFF : 8'h00);
		b = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 255))
			: ($urandom_range(0, 1) ? 8'h7F : 8'h80);
		send_note(v, t, b);
	endtask

	initial begin
		logic [7:0]  rate_byte;
		logic [7:0]  p0;
		logic [7:0]  p1;
		logic [7:0]  p2;
		logic [31:0] pts;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_BREAK_POINTS;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		velocity    <= '0;
		total_level <= '0;
		vol_bias    <= '0;
		burst_left  = 0;
		cur_points  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one table per bend mode, notes at the field extremes and
		// walking through the segments
		for (int m = 0; m < 8; m++) begin
			rate_byte = {((m == 7) ? 4'hF : 4'(m)), 1'(m), 3'(m)};
			load_curve(32'hA5604020, 32'h5A704008, {4{rate_byte}});
			send_note(8'h00, 8'h00, 8'h80);
			send_note(8'hFF, 8'hFF, 8'h7F);
			send_note(8'h10 + 8'(m * 8'h14), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			drain();
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: load_curve(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
				1: load_curve(32'h00000000, 32'h00000000, 32'h00000000);
				2, 5: load_curve($urandom(), $urandom(), $urandom());
				default: begin
					p0 = $urandom_range(0, 255);
					p1 = $urandom_range(0, 255);
					p2 = $urandom_range(0, 255);
					if (p0 > p1) {p0, p1} = {p1, p0};
					if (p1 > p2) {p1, p2} = {p2, p1};
					if (p0 > p1) {p0, p1} = {p1, p0};
					pts = {8'($urandom_range(0, 255)), p2, p1, p0};
					load_curve(pts, $urandom(), $urandom());
				end
			endcase
			for (int n = 0; n < PHASE_NOTES; n++)
				random_note();
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("velocity_level_curve: match");
		else
			$display("velocity_level_curve: mismatch");
		$finish;
	end

endmodule
